@@ src/lkvt_pkg.sv @@
package lkvt_pkg;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SET       = 4'd1,
        OP_LOOKUP    = 4'd2,
        OP_RLOOKUP   = 4'd3,
        OP_READ_POS  = 4'd4,
        OP_WRITE_KEY = 4'd5,
        OP_WRITE_VAL = 4'd6,
        OP_REMOVE    = 4'd7,
        OP_REMOVE_P  = 4'd8,
        OP_CLEAR     = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BADPOS   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic start;     // begin walk
        logic step;      // process one entry (read data valid)
        logic finish;    // form result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk;      // operation needs a walk over entries
        logic last;      // current entry is the last one to visit
        logic stop;      // first-match search has hit
    } stat_t;

endpackage

@@ src/linear_key_value_table_core.sv @@
// channel   dir  tdata fields (low bit up)                          tuser
// s_axis    in   opcode[3:0], in_key, in_value, position[3:0]        -
// m_axis    out  status[1:0], found, out_key, out_value, count_out   -
// The walk reads one key/value pair per cycle from the entry store.
// Lookups stop at the first match; removals and set walk the fill count.
// Reset clears the fill count and controller; entry store is not cleared.
// One item at a time; a held result stalls input until transferred.
module linear_key_value_table_core
    import lkvt_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // opcode, in_key, in_value, position
    input  logic [((8 + KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, found, out_key, out_value, count_out
    output logic [((3 + KEY_BITS + VALUE_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                 m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = 3 + KEY_BITS + VALUE_BITS + CW;

    cmd_t  cmd;
    stat_t stat;
    logic [1:0]            status;
    logic                  found;
    logic [KEY_BITS-1:0]   out_key;
    logic [VALUE_BITS-1:0] out_value;
    logic [CW-1:0]         count_out;

    lkvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    lkvt_datapath #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (s_axis_tdata[3:0]),
        .in_key    (s_axis_tdata[4 +: KEY_BITS]),
        .in_value  (s_axis_tdata[4 + KEY_BITS +: VALUE_BITS]),
        .position  (s_axis_tdata[4 + KEY_BITS + VALUE_BITS +: 4]),
        .status    (status),
        .found     (found),
        .out_key   (out_key),
        .out_value (out_value),
        .count_out (count_out)
    );

    assign m_axis_tdata = {{($bits(m_axis_tdata) - OW){1'b0}},
                           count_out, out_value, out_key, found, status};

endmodule

@@ src/lkvt_datapath.sv @@
module lkvt_datapath
    import lkvt_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [3:0]            opcode,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [3:0]            position,
    output logic [1:0]            status,
    output logic                  found,
    output logic [KEY_BITS-1:0]   out_key,
    output logic [VALUE_BITS-1:0] out_value,
    output logic [CW-1:0]         count_out
);

    logic [KEY_BITS-1:0]   key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];

    logic [3:0]            op_reg;
    logic [KEY_BITS-1:0]   k_reg;
    logic [VALUE_BITS-1:0] v_reg;
    logic [3:0]            p_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         rd_reg;     // read pointer
    logic [CW-1:0]         wr_reg;     // compaction write pointer
    logic                  hit_reg;
    logic [KEY_BITS-1:0]   hk_reg;
    logic [VALUE_BITS-1:0] hv_reg;
    logic [KEY_BITS-1:0]   rk_reg;
    logic [VALUE_BITS-1:0] rv_reg;
    logic [CW-1:0]         vis_reg;    // index of entry in rk/rv

    logic                  pos_ok;
    logic [CW-1:0]         pos_w;
    logic                  pos_op;
    logic                  is_walk_op;
    logic                  match_k, match_v;
    logic                  we;
    logic [IW-1:0]         wa;
    logic [KEY_BITS-1:0]   wk;
    logic [VALUE_BITS-1:0] wv;
    logic                  wk_en, wv_en;

    assign pos_w  = CW'(p_reg);
    // the fill count never exceeds DEPTH, so this also bounds the position
    assign pos_ok = (32'(p_reg) < 32'(count_reg));

    assign pos_op = (opcode == OP_READ_POS) || (opcode == OP_WRITE_KEY)
                    || (opcode == OP_WRITE_VAL);

    always_comb
    begin
        case (op_reg)
            OP_SET, OP_LOOKUP, OP_RLOOKUP, OP_REMOVE: is_walk_op = (count_reg != '0);
            OP_REMOVE_P: is_walk_op = pos_ok;
            default: is_walk_op = 1'b0;
        endcase
    end

    assign match_k = (rk_reg == k_reg);
    assign match_v = (rv_reg == v_reg);

    assign stat.walk = is_walk_op;
    assign stat.last = (vis_reg + CW'(1) >= count_reg);
    assign stat.stop = (op_reg == OP_LOOKUP && match_k) || (op_reg == OP_RLOOKUP && match_v);

    // memory write select
    always_comb
    begin
        we    = 1'b0;
        wa    = '0;
        wk    = rk_reg;
        wv    = v_reg;
        wk_en = 1'b0;
        wv_en = 1'b0;
        if (cmd.finish)
        begin
            wa = pos_w[IW-1:0];
            wk = k_reg;
            wv = v_reg;
            case (op_reg)
                OP_ADD:
                begin
                    wa = count_reg[IW-1:0];
                    if (count_reg < CW'(DEPTH))
                    begin
                        wk_en = 1'b1;
                        wv_en = 1'b1;
                    end
                end
                OP_WRITE_KEY: wk_en = pos_ok;
                OP_WRITE_VAL: wv_en = pos_ok;
                default: ;
            endcase
        end
        else if (cmd.step)
        begin
            case (op_reg)
                OP_SET:
                begin
                    wa    = vis_reg[IW-1:0];
                    wv    = v_reg;
                    wv_en = match_k;
                end
                OP_REMOVE, OP_REMOVE_P:
                begin
                    wa = wr_reg[IW-1:0];
                    wk = rk_reg;
                    wv = rv_reg;
                    if (op_reg == OP_REMOVE)
                        wk_en = !match_k;
                    else
                        wk_en = (vis_reg != pos_w);
                    wv_en = wk_en;
                end
                default: ;
            endcase
        end
        we = wk_en || wv_en;
    end

    always_ff @(posedge clk)
    begin
        if (we && wk_en)
            key_mem[wa] <= wk;
        if (we && wv_en)
            val_mem[wa] <= wv;
        rk_reg <= key_mem[rd_reg[IW-1:0]];
        rv_reg <= val_mem[rd_reg[IW-1:0]];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish)
        begin
            case (op_reg)
                OP_ADD:      if (count_reg < CW'(DEPTH)) count_next = count_reg + CW'(1);
                OP_REMOVE:   count_next = wr_reg;
                OP_REMOVE_P: if (pos_ok) count_next = count_reg - CW'(1);
                OP_CLEAR:    count_next = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            k_reg   <= in_key;
            v_reg   <= in_value;
            p_reg   <= position;
            hit_reg <= 1'b0;
            // position operations sample the addressed entry
            rd_reg  <= pos_op ? CW'(position) : '0;
        end
        if (cmd.start)
        begin
            rd_reg  <= CW'(1);
            vis_reg <= '0;
            wr_reg  <= '0;
        end
        if (cmd.step)
        begin
            rd_reg  <= rd_reg + CW'(1);
            vis_reg <= vis_reg + CW'(1);
            case (op_reg)
                OP_SET:
                    if (match_k) hit_reg <= 1'b1;
                OP_LOOKUP, OP_RLOOKUP:
                    if (stat.stop && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                        hk_reg  <= rk_reg;
                        hv_reg  <= rv_reg;
                    end
                OP_REMOVE:
                    if (match_k)
                    begin
                        hit_reg <= 1'b1;
                        hv_reg  <= rv_reg;
                    end
                    else
                        wr_reg <= wr_reg + CW'(1);
                OP_REMOVE_P:
                    if (vis_reg == pos_w)
                    begin
                        hk_reg <= rk_reg;
                        hv_reg <= rv_reg;
                    end
                    else
                        wr_reg <= wr_reg + CW'(1);
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status    <= ST_OK;
            found     <= 1'b0;
            out_key   <= '0;
            out_value <= '0;
            count_out <= count_next;
            case (op_reg)
                OP_ADD:
                    if (count_reg >= CW'(DEPTH)) status <= ST_FULL;
                OP_SET, OP_REMOVE:
                    if (hit_reg)
                    begin
                        found     <= 1'b1;
                        out_key   <= k_reg;
                        out_value <= (op_reg == OP_SET) ? v_reg : hv_reg;
                    end
                    else
                        status <= ST_NOTFOUND;
                OP_LOOKUP, OP_RLOOKUP:
                    if (hit_reg)
                    begin
                        found     <= 1'b1;
                        out_key   <= hk_reg;
                        out_value <= hv_reg;
                    end
                    else
                        status <= ST_NOTFOUND;
                OP_READ_POS, OP_WRITE_KEY, OP_WRITE_VAL, OP_REMOVE_P:
                    if (pos_ok)
                    begin
                        found     <= 1'b1;
                        out_key   <= (op_reg == OP_WRITE_KEY) ? k_reg :
                                     (op_reg == OP_REMOVE_P) ? hk_reg : rk_reg;
                        out_value <= (op_reg == OP_WRITE_VAL) ? v_reg :
                                     (op_reg == OP_REMOVE_P) ? hv_reg : rv_reg;
                    end
                    else
                        status <= ST_BADPOS;
                default: ;
            endcase
        end
    end

endmodule

@@ src/lkvt_ctrl.sv @@
module lkvt_ctrl
    import lkvt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_fire,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  in_ready,
    output logic  out_valid
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_WAIT;
            S_WAIT: state_next = stat.walk ? S_SCAN : S_DONE;
            S_SCAN: if (stat.last || stat.stop) state_next = S_DONE;
            S_DONE: state_next = S_OUT;
            S_OUT:  if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            S_WAIT: cmd.start = 1'b1;
            S_SCAN: cmd.step = 1'b1;
            S_DONE: cmd.finish = 1'b1;
            S_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
